FILE: rtl/sitoa_pkg.sv
// Package: widths, character codes and pipeline word types for the signed itoa block.
package sitoa_pkg;

    localparam int VALUE_BITS      = 32;
    // decimal digits of 2^(VALUE_BITS-1), via log10(2) ~ 0.30103
    localparam int NUM_DIGITS      = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_W           = 4 * NUM_DIGITS;
    localparam int STEPS_PER_STAGE = 8;
    localparam int NUM_STAGES      = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int PAD_BITS        = NUM_STAGES * STEPS_PER_STAGE;
    localparam int POS_W           = $clog2(NUM_DIGITS);
    localparam int CHAR_W          = 6;

    typedef logic [CHAR_W-1:0] t_char;

    localparam t_char CH_MINUS = t_char'(45);
    localparam t_char CH_ZERO  = t_char'(48);
    localparam t_char CH_NINE  = t_char'(57);

    // word moving through the shift-and-add-3 stages
    typedef struct packed {
        logic                neg;
        logic [BCD_W-1:0]    bcd;
        logic [PAD_BITS-1:0] bin;
    } t_dab;

    // finished decimal word handed to the serialiser
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_dig;

endpackage

FILE: rtl/sitoa_if.sv
// Interfaces: input channel (one integer per word) and output channel (one character per word).
interface sitoa_in_if;
    import sitoa_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_out_if;
    import sitoa_pkg::*;
    logic  valid;
    logic  ready;
    t_char character;
    logic  last;
    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: rtl/sitoa_prep.sv
// Input stage: captures the sign and forms the unsigned magnitude.
module sitoa_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sitoa_in_if.sink            i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output sitoa_pkg::t_dab     o_data
);
    import sitoa_pkg::*;

    logic                  r_valid;
    t_dab                  r_data;
    t_dab                  n_data;
    logic [VALUE_BITS-1:0] mag;

    assign i_in.ready = !r_valid || i_ready;

    always_comb begin
        // two's complement negate; most negative value comes out as 2^(N-1)
        mag = i_in.value[VALUE_BITS-1] ? (~i_in.value + 1'b1) : i_in.value;
        n_data.neg = i_in.value[VALUE_BITS-1];
        n_data.bcd = '0;
        n_data.bin = PAD_BITS'(mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/sitoa_dabble.sv
// One pipeline stage of binary-to-BCD conversion: a fixed number of shift-and-add-3 steps.
module sitoa_dabble (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sitoa_pkg::t_dab i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output sitoa_pkg::t_dab o_data
);
    import sitoa_pkg::*;

    logic r_valid;
    t_dab r_data;
    t_dab n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (n_data.bcd[d*4 +: 4] >= 4'd5) begin
                    n_data.bcd[d*4 +: 4] = n_data.bcd[d*4 +: 4] + 4'd3;
                end
            end
            {n_data.bcd, n_data.bin} = {n_data.bcd, n_data.bin} << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/sitoa_serial.sv
// Serialiser: emits '-' if negative, then the digits from the leading non-zero one down.
module sitoa_serial (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sitoa_pkg::t_dig i_data,
    sitoa_out_if.source     o_out
);
    import sitoa_pkg::*;

    logic             r_busy;
    logic             r_sign;
    logic [BCD_W-1:0] r_bcd;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] msd;
    logic             last_now;
    logic             take;
    logic [3:0]       digit;

    // leading non-zero digit; zero gives digit 0
    always_comb begin
        msd = '0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (i_data.bcd[k*4 +: 4] != 4'd0) begin
                msd = POS_W'(k);
            end
        end
    end

    assign last_now = !r_sign && (r_pos == '0);
    assign take     = r_busy && o_out.ready;
    assign o_ready  = !r_busy || (o_out.ready && last_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_ready && i_valid) begin
            r_busy <= 1'b1;
        end else if (take && last_now) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sign <= i_data.neg;
            r_bcd  <= i_data.bcd;
            r_pos  <= msd;
        end else if (take) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else if (!last_now) begin
                r_pos <= r_pos - 1'b1;
            end
        end
    end

    assign digit           = r_bcd[r_pos*4 +: 4];
    assign o_out.valid     = r_busy;
    assign o_out.character = r_sign ? CH_MINUS : (CH_ZERO + t_char'(digit));
    assign o_out.last      = last_now;

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII character stream.
//
// Each input word is a two's complement integer of VALUE_BITS bits; the block
// answers with its decimal text, one ASCII character per output word, most
// significant first: '-' for a negative value, then the digits with leading
// zeros suppressed (zero gives a lone '0'); the most negative value comes out
// exactly. The final character of a number has last set. Words pass through a
// register stage that takes the magnitude, NUM_STAGES shift-and-add-3 stages
// (8 bit steps each, 4 stages at 32 bits) and a serialiser. The serialiser
// sends one character per cycle while the output channel is ready, and a
// number has 1 to 11 characters at 32 bits; that sets the sustained rate, and
// the pipeline ahead of it keeps later numbers queued so that the next
// number's first character follows the previous last one directly.
// The pipeline stalls cleanly under back-pressure on the output channel.
// Nothing is kept from one number to the next.
module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sitoa_in_if.sink    i_in,
    sitoa_out_if.source o_out
);
    import sitoa_pkg::*;

    logic p_valid  [NUM_STAGES+1];
    logic p_ready  [NUM_STAGES+1];
    t_dab p_data   [NUM_STAGES+1];
    t_dig ser_data;

    // sign and magnitude
    sitoa_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (p_valid[0]),
        .i_ready (p_ready[0]),
        .o_data  (p_data[0])
    );

    // binary to BCD, spread evenly over the stages
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dab
        sitoa_dabble u_dab (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (p_valid[g]),
            .o_ready (p_ready[g]),
            .i_data  (p_data[g]),
            .o_valid (p_valid[g+1]),
            .i_ready (p_ready[g+1]),
            .o_data  (p_data[g+1])
        );
    end

    assign ser_data.neg = p_data[NUM_STAGES].neg;
    assign ser_data.bcd = p_data[NUM_STAGES].bcd;

    // character output
    sitoa_serial u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid[NUM_STAGES]),
        .o_ready (p_ready[NUM_STAGES]),
        .i_data  (ser_data),
        .o_out   (o_out)
    );

    // nothing is offered straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");

    // a number never ends on its sign
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (o_out.character != CH_MINUS))
        else $error("sign marked as last character");

    // a taken sign is followed at once by a digit of the same number
    a_sign_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.character == CH_MINUS)
        |=> (o_out.valid && o_out.character != CH_MINUS))
        else $error("sign not followed by a digit");

    // characters other than the sign are decimal digits
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.character != CH_MINUS)
        |-> (o_out.character >= CH_ZERO && o_out.character <= CH_NINE))
        else $error("character outside the digit range");

endmodule

FILE: test/signed_int_to_decimal_ascii_tb.sv
// Testbench for the signed integer to decimal ASCII block: directed and random words, self-checked.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
    import sitoa_pkg::*;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    // one expected output word: a character and its end-of-number flag
    typedef struct {
        t_char character;
        logic  last;
    } t_text_char;

    // Works out the decimal text of each accepted integer and matches the
    // character stream against it, oldest first.
    class decimal_text_board;
        t_text_char  text_queue[$];
        int unsigned errors;

        function void note_value(t_value value);
            logic [VALUE_BITS-1:0] magnitude;
            t_char                 digit_chars[$];
            t_text_char            entry;
            magnitude = value;
            // two's complement negate; the most negative value comes out as 2^(N-1)
            if (value[VALUE_BITS-1])
                magnitude = ~magnitude + 1'b1;
            do begin
                digit_chars.push_front(CH_ZERO + t_char'(magnitude % 10));
                magnitude = magnitude / 10;
            end while (magnitude != 0);
            if (value[VALUE_BITS-1]) begin
                entry.character = CH_MINUS;
                entry.last      = 1'b0;
                text_queue.push_back(entry);
            end
            foreach (digit_chars[i]) begin
                entry.character = digit_chars[i];
                entry.last      = (i == digit_chars.size() - 1);
                text_queue.push_back(entry);
            end
        endfunction

        function void check_char(t_char character, logic last);
            t_text_char expected;
            if (text_queue.size() == 0) begin
                $error("character: none expected, got %0d (last %0b)", character, last);
                errors++;
                return;
            end
            expected = text_queue.pop_front();
            if (character !== expected.character) begin
                $error("character: expected %0d, got %0d", expected.character, character);
                errors++;
            end
            if (last !== expected.last) begin
                $error("last: expected %0b, got %0b", expected.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return text_queue.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sitoa_in_if  in_if ();
    sitoa_out_if out_if ();

    decimal_text_board text_board = new();

    // idle chance on both sides: 0 means none, otherwise one in idle_level
    int unsigned idle_level;

    signed_int_to_decimal_ascii u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous cap: the slowest correct run is well under a millisecond
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // sink side: random stall bursts with ready held low
    initial begin : output_ready_driver
        int unsigned stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else if (idle_level != 0 && $urandom_range(0, idle_level - 1) == 0) begin
                out_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 10);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // every accepted character word goes to the board
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            text_board.check_char(out_if.character, out_if.last);
    end

    // Offer one integer from a falling edge and hold it until taken. valid is
    // only raised here, so back-to-back words keep it high with no glitch.
    task automatic send_value(input t_value value);
        in_if.valid <= 1'b1;
        in_if.value <= value;
        do @(posedge i_clk); while (!in_if.ready);
        text_board.note_value(value);
        @(negedge i_clk);
    endtask

    // source side: occasional gap between words, with valid low
    task automatic source_gap();
        if (idle_level != 0 && $urandom_range(0, idle_level - 1) == 0) begin
            in_if.valid <= 1'b0;
            in_if.value <= t_value'($urandom);
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
    endtask

    // Random integer: full-range words, short numbers of every length,
    // values either side of each power of ten, and the two extremes.
    function automatic t_value random_value();
        int unsigned       kind;
        int unsigned       decade;
        logic [VALUE_BITS-1:0] raw;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            raw = $urandom;
        end else if (kind <= 6) begin
            decade = 10 ** $urandom_range(1, 9);
            raw    = $urandom_range(decade - 1, 0);
            if ($urandom_range(0, 1)) raw = -raw;
        end else if (kind <= 8) begin
            decade = 10 ** $urandom_range(0, 9);
            raw    = decade + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) raw = -raw;
        end else if ($urandom_range(0, 1)) begin
            raw = {1'b0, {(VALUE_BITS-1){1'b1}}} - $urandom_range(0, 3);
        end else begin
            raw = {1'b1, {(VALUE_BITS-1){1'b0}}} + $urandom_range(0, 3);
        end
        return t_value'(raw);
    endfunction

    initial begin : stimulus
        t_value directed_values[$];
        int     random_count;
        directed_values = '{
            0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
            999_999_999, -999_999_999, 1_000_000_000, -1_000_000_000,
            1_234_567_890, -1_234_567_890,
            32'sh7FFF_FFFF,          // largest: ten digits, no sign
            32'sh8000_0000,          // most negative: eleven characters
            32'sh8000_0001,
            32'sh5555_5555, 32'shAAAA_AAAA,
            32'sh0000_FFFF, 32'shFFFF_0000
        };
        random_count = 447;

        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.value = '0;
        idle_level  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words, with light idling on both sides
        idle_level = 4;
        foreach (directed_values[i]) begin
            source_gap();
            send_value(directed_values[i]);
        end

        for (int n = 0; n < random_count; n++) begin
            // switch idling density every 60 words; the final stretch runs flat out
            if (n % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_level = 0;
                    1: idle_level = 3;
                    default: idle_level = 10;
                endcase
            end
            if (n >= random_count - 60)
                idle_level = 0;
            // hold the source off once until the pipeline has fully drained
            if (n == random_count / 2) begin
                in_if.valid <= 1'b0;
                while (text_board.pending() != 0) @(negedge i_clk);
            end
            source_gap();
            send_value(random_value());
        end

        in_if.valid <= 1'b0;
        while (text_board.pending() != 0) @(negedge i_clk);
        // allow ample margin for strays after the last expected character
        repeat (4 * (NUM_STAGES + 2)) @(negedge i_clk);

        if (text_board.errors == 0 && text_board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
